>>> hdl/mfms_pkg.sv
// shared types, constants and a helper for the multi-frame median select block
package mfms_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int SAMPLE_W   = 8;
   localparam int CFG_W      = 4;
   localparam int LANE_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam int REG_FRAMES_IN_USE = 0;

   localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);

   typedef logic [SAMPLE_W-1:0]   sample_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [LANE_IDX_W-1:0] lane_idx_type;

   // per-lane result passed to the merge stage
   typedef struct packed {
      logic      used;
      count_type rank;
   } lane_result_type;

   // clamp the programmed frame count into 1..MAX_FRAMES
   function automatic count_type used_count(input logic [CFG_W-1:0] frames);
      count_type n;
      if (frames == '0) begin
         n = count_type'(1);
      end else if ({{CNT_W{1'b0}}, frames} > (CNT_W + CFG_W)'(MAX_FRAMES)) begin
         n = count_type'(MAX_FRAMES);
      end else begin
         n = count_type'(frames);
      end
      return n;
   endfunction

endpackage

>>> hdl/mfms_lane.sv
// one lane: stable rank of its own sample among the frames in use
module mfms_lane (
   input  mfms_pkg::lane_idx_type    lane_idx,
   input  mfms_pkg::sample_type      samples [mfms_pkg::MAX_FRAMES],
   input  mfms_pkg::count_type       used_n,
   output mfms_pkg::lane_result_type result
);
   import mfms_pkg::*;

   sample_type own;
   count_type  rank;
   logic [MAX_FRAMES-1:0] beats;

   assign own = samples[lane_idx];

   // one compare per other lane, ties broken by lane order
   always_comb begin
      for (int j = 0; j < MAX_FRAMES; j++) begin
         beats[j] = (count_type'(j) < used_n)
                    && (LANE_IDX_W'(j) != lane_idx)
                    && ((samples[j] < own)
                        || ((samples[j] == own) && (LANE_IDX_W'(j) < lane_idx)));
      end
   end

   // count of lanes that sort ahead of this one
   always_comb begin
      rank = '0;
      for (int j = 0; j < MAX_FRAMES; j++) begin
         rank = rank + count_type'(beats[j]);
      end
   end

   assign result.used = ({{(CNT_W - LANE_IDX_W){1'b0}}, lane_idx} < used_n);
   assign result.rank = rank;

endmodule

>>> hdl/mfms_merge.sv
// merge stage: picks the used lane whose rank is the middle index
module mfms_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  mfms_pkg::lane_result_type results [mfms_pkg::MAX_FRAMES],
   input  mfms_pkg::sample_type      samples [mfms_pkg::MAX_FRAMES],
   input  mfms_pkg::count_type       half_n,
   output mfms_pkg::sample_type      median
);
   import mfms_pkg::*;

   logic [MAX_FRAMES-1:0] match;

   // exactly one used lane holds the middle rank
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = results[i].used && (results[i].rank == half_n);
      end
   end

   // and-or select over the one-hot match
   always_comb begin
      median = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         median = median | (samples[i] & {SAMPLE_W{match[i]}});
      end
   end

   a_one_match: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> $onehot(match))
      else $error("median select: lane match is not one-hot");

   a_used_lane_zero: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> results[0].used)
      else $error("median select: lane 0 not in use");

   a_half_in_range: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> (half_n < count_type'(MAX_FRAMES)))
      else $error("median select: middle index out of range");

endmodule

>>> hdl/multi_frame_median_select.sv
// top level of the multi-frame median select block
// Usage:
//   req channel: one word per cycle carries sample_0..sample_7, the same
//   colour component of one pixel from eight aligned frames. A word is
//   taken at a clock edge with req_valid high and req_stall low.
//   rsp channel: one word per request with median_sample, the used sample
//   at sorted index frames_in_use/2 (upper middle for an even count).
//   frames_in_use is set through the APB port at byte address 0; 0 acts as
//   1 and values above 8 act as 8. Write it only while the block is idle.
// Pipeline: the rank lanes feed the lane stage registers, then the merge
//   result goes into the output register that drives rsp_valid.
// Throughput: one word per cycle while rsp_stall is low; eight rank lanes
//   work side by side, so there is no iteration and no dependence between words.
// Reset: synchronous, clears both pipeline valids and loads frames_in_use
//   with 8. The block accepts words in the first cycle after reset.
// Stall: a held rsp_stall keeps the output word stable; the block still
//   takes one more word into its lane stage and raises req_stall only once
//   both stages are full.
module multi_frame_median_select (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mfms_pkg::sample_type                 req_sample_0,
   input  mfms_pkg::sample_type                 req_sample_1,
   input  mfms_pkg::sample_type                 req_sample_2,
   input  mfms_pkg::sample_type                 req_sample_3,
   input  mfms_pkg::sample_type                 req_sample_4,
   input  mfms_pkg::sample_type                 req_sample_5,
   input  mfms_pkg::sample_type                 req_sample_6,
   input  mfms_pkg::sample_type                 req_sample_7,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mfms_pkg::sample_type                 rsp_median_sample,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mfms_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mfms_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mfms_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import mfms_pkg::*;

   logic [CFG_W-1:0] frames_in_use_ff, frames_in_use_in;
   logic             reg_hit;
   logic             cfg_write;

   sample_type       req_samples [MAX_FRAMES];
   count_type        used_n;
   lane_result_type  lane_res [MAX_FRAMES];

   logic             s1_valid_ff, s1_valid_in;
   sample_type       s1_sample_ff [MAX_FRAMES];
   lane_result_type  s1_res_ff [MAX_FRAMES];
   count_type        s1_half_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_median_ff;
   sample_type       median;

   logic             out_move;
   logic             s1_move;
   logic             req_take;

   // register decode
   assign reg_hit   = (paddr[CSR_ADDR_W-1:2] == (CSR_ADDR_W - 2)'(REG_FRAMES_IN_USE));
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = reg_hit ? {{(CSR_DATA_W - CFG_W){1'b0}}, frames_in_use_ff} : '0;

   always_comb begin
      frames_in_use_in = frames_in_use_ff;
      if (cfg_write && reg_hit) begin
         frames_in_use_in = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_RESET;
      end else begin
         frames_in_use_ff <= frames_in_use_in;
      end
   end

   // gather the request word into lane order
   assign req_samples[0] = req_sample_0;
   assign req_samples[1] = req_sample_1;
   assign req_samples[2] = req_sample_2;
   assign req_samples[3] = req_sample_3;
   assign req_samples[4] = req_sample_4;
   assign req_samples[5] = req_sample_5;
   assign req_samples[6] = req_sample_6;
   assign req_samples[7] = req_sample_7;

   assign used_n = used_count(frames_in_use_ff);

   // rank lanes
   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_lane
      mfms_lane u_lane (
         .lane_idx (LANE_IDX_W'(g)),
         .samples  (req_samples),
         .used_n   (used_n),
         .result   (lane_res[g])
      );
   end

   // pipeline flow control
   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = !s1_valid_ff || out_move;
   assign req_stall = !s1_move;
   assign req_take  = req_valid && s1_move;

   assign s1_valid_in  = s1_move ? req_valid : s1_valid_ff;
   assign rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;

   // lane stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff <= req_samples;
         s1_res_ff    <= lane_res;
         s1_half_ff   <= used_n >> 1;
      end
   end

   // merge into the output register
   mfms_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .results  (s1_res_ff),
      .samples  (s1_sample_ff),
      .half_n   (s1_half_ff),
      .median   (median)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move && s1_valid_ff) begin
         rsp_median_ff <= median;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_sample = rsp_median_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("median select: request stalled with room in the pipeline");

   a_take_fills_lane_stage: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("median select: accepted word lost from lane stage");

   a_lane_stage_to_output: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_move) |=> rsp_valid_ff)
      else $error("median select: lane stage word not passed to output");

   a_cfg_write_lands: assert property (@(posedge clock) disable iff (reset)
      (cfg_write && reg_hit) |=> (frames_in_use_ff == $past(pwdata[CFG_W-1:0])))
      else $error("median select: frame count write not taken");

endmodule

>>> dv/testbench.sv
// self-checking testbench for the multi-frame median select block
`timescale 1ns / 1ps

module testbench;
   import mfms_pkg::*;

   typedef logic [MAX_FRAMES-1:0][SAMPLE_W-1:0] frame_set_type;

   localparam int UNMAPPED_REG = 1;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 90;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic          req_valid = 1'b0;
   logic          req_stall;
   frame_set_type req_frames = '0;

   // response side
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_median_sample;

   // apb port
   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // testbench state
   frame_set_type    pending_frame_sets[$];
   sample_type       expected_medians[$];
   logic [CFG_W-1:0] frames_setting = FRAMES_RESET;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               failures       = 0;

   multi_frame_median_select dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_0      (req_frames[0]),
      .req_sample_1      (req_frames[1]),
      .req_sample_2      (req_frames[2]),
      .req_sample_3      (req_frames[3]),
      .req_sample_4      (req_frames[4]),
      .req_sample_5      (req_frames[5]),
      .req_sample_6      (req_frames[6]),
      .req_sample_7      (req_frames[7]),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_median_sample (rsp_median_sample),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // median of the used lanes, upper middle for an even count
   function automatic sample_type median_of_frames(frame_set_type s, logic [CFG_W-1:0] frames);
      sample_type v[MAX_FRAMES];
      sample_type t;
      int         n;
      n = (frames == '0) ? 1 : ((int'(frames) > MAX_FRAMES) ? MAX_FRAMES : int'(frames));
      for (int i = 0; i < n; i++) v[i] = s[i];
      for (int i = 0; i < n - 1; i++) begin
         for (int j = 0; j < n - 1 - i; j++) begin
            if (v[j] > v[j+1]) begin
               t      = v[j];
               v[j]   = v[j+1];
               v[j+1] = t;
            end
         end
      end
      return v[n/2];
   endfunction

   // queue one word for the driver
   function automatic void add_word(frame_set_type w);
      pending_frame_sets = {pending_frame_sets, w};
   endfunction

   // random word: mostly full-range bytes, some with many duplicates or extremes
   function automatic frame_set_type random_frame_set();
      frame_set_type s;
      sample_type    pool[3];
      int            mode;
      mode = $urandom_range(9);
      for (int k = 0; k < 3; k++) pool[k] = sample_type'($urandom);
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (mode < 6)
            s[i] = sample_type'($urandom);
         else if (mode < 8)
            s[i] = pool[$urandom_range(2)];
         else
            s[i] = $urandom_range(1) ? 8'hff : 8'h00;
      end
      return s;
   endfunction

   // driver: a held word stays put until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_frame_sets.size() == 0 || $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
         end else begin
            req_valid  <= 1'b1;
            req_frames <= pending_frame_sets.pop_front();
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_medians = {expected_medians,
                                median_of_frames(req_frames, frames_setting)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_medians.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected word: median_sample=%0d", rsp_median_sample);
            end else if (rsp_median_sample !== expected_medians[0]) begin
               failures++;
               if (failures <= 10)
                  $display("median_sample mismatch: expected %0d actual %0d (frames %0d)",
                           expected_medians[0], rsp_median_sample, frames_setting);
               void'(expected_medians.pop_front());
            end else begin
               void'(expected_medians.pop_front());
            end
         end
      end
   end

   // apb write: setup cycle, then access cycle
   task automatic csr_write(int index, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * index);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == REG_FRAMES_IN_USE) frames_setting = data[CFG_W-1:0];
   endtask

   // apb read of the frame count, compared with the shadow copy
   task automatic csr_read_check();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_ADDR_W'(4 * REG_FRAMES_IN_USE);
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata !== CSR_DATA_W'(frames_setting)) begin
         failures++;
         if (failures <= 10)
            $display("frames_in_use readback mismatch: expected %0d actual %0d",
                     frames_setting, prdata);
      end
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // wait until every word is sent and answered, then let the pipeline settle
   task automatic drain();
      do @(posedge clock);
      while (pending_frame_sets.size() != 0 || req_valid || expected_medians.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // stimulus and phase control
   initial begin
      frame_set_type    s;
      logic [CFG_W-1:0] counts[11];
      logic [CSR_DATA_W-1:0] data;

      counts = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset frame count
      add_word('0);
      add_word({MAX_FRAMES{8'hff}});
      for (int i = 0; i < MAX_FRAMES; i++) s[i] = sample_type'(i * 30);
      add_word(s);
      for (int i = 0; i < MAX_FRAMES; i++) s[i] = sample_type'(255 - i * 30);
      add_word(s);
      for (int i = 0; i < MAX_FRAMES; i++) s[i] = (i % 2) ? 8'hff : 8'h00;
      add_word(s);
      add_word({8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa});
      add_word({8'd7, 8'd7, 8'd7, 8'd1, 8'd7, 8'd200, 8'd7, 8'd7});
      for (int k = 0; k < MAX_FRAMES; k++) begin
         s    = '0;
         s[k] = 8'hff;
         add_word(s);
      end
      for (int k = 0; k < MAX_FRAMES; k++) begin
         s    = {MAX_FRAMES{8'hff}};
         s[k] = 8'h00;
         add_word(s);
      end
      drain();

      // random phases over frame counts and idle patterns
      for (int k = 0; k < PHASES; k++) begin
         case (k % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         data        = $urandom;
         data[CFG_W-1:0] = (k < 11) ? counts[k] : CFG_W'($urandom_range(15));
         csr_write(REG_FRAMES_IN_USE, data);
         csr_read_check();
         // writes to an unmapped register must leave the frame count alone
         if (k == 3) begin
            csr_write(UNMAPPED_REG, $urandom);
            csr_read_check();
         end
         for (int i = 0; i < PHASE_WORDS / 2; i++) add_word(random_frame_set());
         // sender holds off until everything is answered
         if (k == 5) drain();
         for (int i = 0; i < PHASE_WORDS / 2; i++) add_word(random_frame_set());
         drain();
      end

      repeat (10) @(posedge clock);
      if (expected_medians.size() != 0) failures++;
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // overall run limit
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
